// File: design/ptt_pkg.sv
package ptt_pkg;

  // Field widths
  localparam int POS_W     = 24;   // positions, 1/256 unit
  localparam int DIFF_W    = 25;   // exact differences of two positions
  localparam int MAG_W     = 24;   // magnitude of a difference
  localparam int CFG_IDX_W = 2;
  localparam int PAN_W     = 16;
  localparam int TILT_W    = 15;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z = 2'd2;

  // Square root datapath
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 64;

  // CORDIC datapath: vector components and angle accumulator
  localparam int CW        = 44;
  localparam int ZW        = 25;
  localparam int TAB_DEPTH = 24;
  localparam int STEP_W    = $clog2(TAB_DEPTH);
  localparam int ATAN_W    = 22;

  // Angles in 1/65536 degree
  localparam int DEG_ONE  = 65536;
  localparam int DEG_90   = 90 * DEG_ONE;
  localparam int DEG_180  = 180 * DEG_ONE;
  localparam int BIAS_DEG = 512;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/ptt_cordic.sv
module ptt_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [ptt_pkg::CW-1:0] x_i,
  input  logic signed [ptt_pkg::CW-1:0] y_i,
  output ptt_pkg::unit_stat_t           stat_o,
  output logic signed [ptt_pkg::ZW-1:0] z_o
);
  import ptt_pkg::*;

  localparam logic [STEP_W-1:0] LAST = STEP_W'(STEPS - 1);

  logic signed [CW-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, step_ang;
  logic [STEP_W-1:0]    i_q;
  logic                 busy_q, done_q;
  logic                 x_zero_q, y_neg_q, y_zero_q;

  // one vectoring micro-rotation per cycle, driving y toward zero
  always_comb begin
    dx       = y_q >>> i_q;
    dy       = x_q >>> i_q;
    step_ang = signed'({{(ZW-ATAN_W){1'b0}}, atan_lut(i_q)});
    if (!y_q[CW-1]) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + step_ang;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - step_ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q      <= x_i;
      y_q      <= y_i;
      z_q      <= '0;
      x_zero_q <= (x_i == '0);
      y_neg_q  <= y_i[CW-1];
      y_zero_q <= (y_i == '0);
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // vector on the y axis: straight up, straight down, or nothing at all
  always_comb begin
    if (x_zero_q) begin
      if (y_zero_q)     z_o = '0;
      else if (y_neg_q) z_o = -ZW'(DEG_90);
      else              z_o = ZW'(DEG_90);
    end else begin
      z_o = z_q;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: design/ptt_isqrt.sv
module ptt_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ptt_pkg::MAG_W-1:0]   a_mag_i,
  input  logic [ptt_pkg::MAG_W-1:0]   b_mag_i,
  output ptt_pkg::unit_stat_t         stat_o,
  output logic [ptt_pkg::ROOT_W-1:0]  root_o
);
  import ptt_pkg::*;

  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SQ_SHIFT = 14;
  localparam int K_W      = $clog2(ROOT_W);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQA  = 3'd1;
  localparam logic [2:0] PH_SQB  = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_ROOT = 3'd4;

  logic [2:0]        ph_q;
  logic [K_W-1:0]    k_q;
  logic              done_q;
  logic [MAG_W-1:0]  a_q, b_q, op;
  logic [PROD_W-1:0] prod, p_q, acc_q;
  logic [SUM_W-1:0]  sum;
  logic [RAD_W-1:0]  n_q, r_q, bit_v, trial;
  logic              take;

  // one 24x24 squarer, used for a then b
  assign op    = (ph_q == PH_SQA) ? a_q : b_q;
  assign prod  = op * op;
  assign sum   = {1'b0, acc_q} + {1'b0, p_q};

  // digit-by-digit root, one result bit per cycle
  assign bit_v = RAD_W'(1) << {k_q, 1'b0};
  assign trial = r_q + bit_v;
  assign take  = (n_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      k_q    <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      ph_q   <= PH_SQA;
      done_q <= 1'b0;
    end else begin
      case (ph_q)
        PH_SQA: ph_q <= PH_SQB;
        PH_SQB: ph_q <= PH_SUM;
        PH_SUM: begin
          ph_q <= PH_ROOT;
          k_q  <= '1;
        end
        PH_ROOT: begin
          k_q <= k_q - 1'b1;
          if (k_q == '0) begin
            ph_q   <= PH_IDLE;
            done_q <= 1'b1;
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_mag_i;
      b_q <= b_mag_i;
    end
    case (ph_q)
      PH_SQA: p_q <= prod;
      PH_SQB: begin
        p_q   <= prod;
        acc_q <= p_q;
      end
      PH_SUM: begin
        n_q <= RAD_W'(sum) << SQ_SHIFT;
        r_q <= '0;
      end
      PH_ROOT: begin
        if (take) begin
          n_q <= n_q - trial;
          r_q <= (r_q >> 1) + bit_v;
        end else begin
          r_q <= r_q >> 1;
        end
      end
      default: ;
    endcase
  end

  assign root_o      = r_q[ROOT_W-1:0];
  assign stat_o.busy = (ph_q != PH_IDLE);
  assign stat_o.done = done_q;

endmodule

// File: design/pan_tilt_angles_to_target.sv
// Channel | Dir | Handshake                      | Beat contents
// --------+-----+--------------------------------+-----------------------------------------
// config  | in  | cfg_we_i                       | cfg_index_i, cfg_data_i (eye_x/y/z)
// target  | in  | in_valid_i / in_stall_o        | target_x_i, target_y_i, target_z_i
// angles  | out | out_valid_o / out_stall_i      | pan_angle_o, tilt_angle_o, *_updated_o
//
// One target beat at a time: in_stall_o is low only while the sequencer is idle.
// Each beat runs the square root (two squares, a sum, 32 root steps) for the
// horizontal distance, then the tilt CORDIC pass; the pan CORDIC pass runs in
// the shadow of the square root.
// The result sits in an output register; a stalled result holds and the next beat's
// computation still proceeds, only the final commit waits for the register to free.
// Reset clears the eye position, the held angles and the sequencer; nothing sweeps.
module pan_tilt_angles_to_target #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ptt_pkg::POS_W-1:0]            cfg_data_i,
  // target beat
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ptt_pkg::POS_W-1:0]     target_x_i,
  input  logic signed [ptt_pkg::POS_W-1:0]     target_y_i,
  input  logic signed [ptt_pkg::POS_W-1:0]     target_z_i,
  // angle beat
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ptt_pkg::PAN_W-1:0]            pan_angle_o,
  output logic signed [ptt_pkg::TILT_W-1:0]    tilt_angle_o,
  output logic                                 pan_updated_o,
  output logic                                 tilt_updated_o
);
  import ptt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;  // kick off pan CORDIC and square root
  localparam logic [2:0] ST_PAN    = 3'd2;
  localparam logic [2:0] ST_WAIT_H = 3'd3;  // wait for horizontal distance
  localparam logic [2:0] ST_TILT   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;  // commit once the output register is free

  // angle post-processing width (1/65536 degree sums up to ~460 degrees plus bias)
  localparam int PW        = 28;
  localparam int OUT_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam int OP_PAD_D  = CW - DIFF_W - 16;
  localparam int OP_PAD_M  = CW - MAG_W - 16;
  localparam int OP_PAD_H  = CW - ROOT_W - 9;

  localparam logic signed [PW-1:0] DEG180_P = PW'(DEG_180);
  localparam logic signed [PW-1:0] BIAS_IN  = PW'(BIAS_DEG * DEG_ONE);
  localparam logic signed [PW-1:0] HALF_LSB = PW'(2 ** (OUT_SHIFT - 1));
  localparam logic signed [PW-1:0] BIAS_OUT = PW'(BIAS_DEG * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [PW-1:0] PAN_LO   = PW'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [PW-1:0] PAN_HI   = PW'(450 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [PW-1:0] TILT_LO  = PW'(-90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [PW-1:0] TILT_HI  = PW'(90 * (2 ** ANGLE_FRAC_BITS));

  // round half up to output units, then clamp
  function automatic logic signed [PW-1:0] to_out(input logic signed [PW-1:0] v,
                                                  input logic signed [PW-1:0] lo,
                                                  input logic signed [PW-1:0] hi);
    logic signed [PW-1:0] biased, r;
    biased = v + BIAS_IN;
    if (biased < 0) biased = '0;
    r = ((biased + HALF_LSB) >>> OUT_SHIFT) - BIAS_OUT;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  logic [2:0]               state_q, state_d;
  logic signed [POS_W-1:0]  eye_x_q, eye_y_q, eye_z_q;
  logic signed [DIFF_W-1:0] a_q, b_q, c_q, neg_a, neg_b, y_sel;
  logic [MAG_W-1:0]         a_mag, b_mag;
  logic                     in_take, out_free, commit, b_pos, pan_up, tilt_up;

  logic                     cordic_start, sqrt_start;
  logic signed [CW-1:0]     cordic_x, cordic_y;
  logic signed [ZW-1:0]     cordic_z;
  unit_stat_t               cordic_stat, sqrt_stat;
  logic [ROOT_W-1:0]        h_root;

  logic signed [PW-1:0]     pan_sum, pan_full, tilt_full;
  logic [PAN_W-1:0]         pan_res_q, held_pan_q;
  logic signed [TILT_W-1:0] held_tilt_q;
  logic                     out_valid_q, pan_upd_q, tilt_upd_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_DONE) && out_free;

  // a = eye_x - x, b = y - eye_y, c = z - eye_z; pan/tilt are refreshed only
  // when the target is off the camera's x (pan) or z (tilt) coordinate
  assign neg_a   = -a_q;
  assign neg_b   = -b_q;
  assign a_mag   = a_q[DIFF_W-1] ? neg_a[MAG_W-1:0] : a_q[MAG_W-1:0];
  assign b_mag   = b_q[DIFF_W-1] ? neg_b[MAG_W-1:0] : b_q[MAG_W-1:0];
  assign b_pos   = !b_q[DIFF_W-1] && (b_q != '0);
  assign pan_up  = (a_q != '0);
  assign tilt_up = (c_q != '0);

  // Pan vector is (|b|, a) with a negated for b < 0. With b zero this leaves
  // x = 0 and the CORDIC unit answers +-90 degrees by the sign of a.
  assign y_sel = b_q[DIFF_W-1] ? neg_a : a_q;

  always_comb begin
    if (state_q == ST_LOAD) begin
      cordic_x = signed'({{OP_PAD_M{1'b0}}, b_mag, 16'b0});
      cordic_y = signed'({{OP_PAD_D{y_sel[DIFF_W-1]}}, y_sel, 16'b0});
    end else begin
      // tilt vector: horizontal distance (1/128 position step) and c, both scaled up
      cordic_x = signed'({{OP_PAD_H{1'b0}}, h_root, 9'b0});
      cordic_y = signed'({{OP_PAD_D{c_q[DIFF_W-1]}}, c_q, 16'b0});
    end
  end

  assign sqrt_start   = (state_q == ST_LOAD);
  assign cordic_start = (state_q == ST_LOAD) || ((state_q == ST_WAIT_H) && sqrt_stat.done);

  ptt_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .x_i    (cordic_x),
    .y_i    (cordic_y),
    .stat_o (cordic_stat),
    .z_o    (cordic_z)
  );

  ptt_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .a_mag_i(a_mag),
    .b_mag_i(b_mag),
    .stat_o (sqrt_stat),
    .root_o (h_root)
  );

  // pan = atan + 180, another 180 when the target lies at greater y
  assign pan_sum   = PW'(cordic_z) + DEG180_P + (b_pos ? DEG180_P : PW'(0));
  assign pan_full  = to_out(pan_sum, PAN_LO, PAN_HI);
  assign tilt_full = to_out(PW'(cordic_z), TILT_LO, TILT_HI);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_PAN;
      ST_PAN:    if (!cordic_stat.busy && cordic_stat.done) state_d = ST_WAIT_H;
      ST_WAIT_H: if (sqrt_stat.done) state_d = ST_TILT;
      ST_TILT:   if (!cordic_stat.busy && cordic_stat.done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      eye_x_q     <= '0;
      eye_y_q     <= '0;
      eye_z_q     <= '0;
      held_pan_q  <= '0;
      held_tilt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_EYE_X: eye_x_q <= cfg_data_i;
          CFG_EYE_Y: eye_y_q <= cfg_data_i;
          CFG_EYE_Z: eye_z_q <= cfg_data_i;
          default:   ;
        endcase
      end
      if (commit) begin
        out_valid_q <= 1'b1;
        if (pan_up)  held_pan_q  <= pan_res_q;
        if (tilt_up) held_tilt_q <= tilt_full[TILT_W-1:0];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_q <= {eye_x_q[POS_W-1], eye_x_q} - {target_x_i[POS_W-1], target_x_i};
      b_q <= {target_y_i[POS_W-1], target_y_i} - {eye_y_q[POS_W-1], eye_y_q};
      c_q <= {target_z_i[POS_W-1], target_z_i} - {eye_z_q[POS_W-1], eye_z_q};
    end
    if ((state_q == ST_PAN) && cordic_stat.done) begin
      pan_res_q <= pan_full[PAN_W-1:0];
    end
    if (commit) begin
      pan_upd_q  <= pan_up;
      tilt_upd_q <= tilt_up;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pan_angle_o    = held_pan_q;
  assign tilt_angle_o   = held_tilt_q;
  assign pan_updated_o  = pan_upd_q;
  assign tilt_updated_o = tilt_upd_q;

endmodule

// File: design/ptt_checker.sv
module ptt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] pan_angle_o,
  input logic [14:0] tilt_angle_o,
  input logic        pan_updated_o,
  input logic        tilt_updated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("angle beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pan_angle_o) && $stable(tilt_angle_o) &&
                                   $stable(pan_updated_o) && $stable(tilt_updated_o))
    else $error("angle beat changed while stalled");

  // one target in flight: the cycle after a beat is taken the input stalls
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("target taken while another is in flight");

  // a held angle only moves with a fresh beat that reports it recomputed
  a_pan_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pan_angle_o != $past(pan_angle_o) |-> out_valid_o && pan_updated_o)
    else $error("pan moved without an update");

  a_tilt_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tilt_angle_o != $past(tilt_angle_o) |-> out_valid_o && tilt_updated_o)
    else $error("tilt moved without an update");

endmodule

bind pan_tilt_angles_to_target ptt_checker u_ptt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pan_angle_o   (pan_angle_o),
  .tilt_angle_o  (tilt_angle_o),
  .pan_updated_o (pan_updated_o),
  .tilt_updated_o(tilt_updated_o)
);

// File: tb/tb_top.sv
module tb_top;

  // DUT configuration; the predictor below is written for exactly these values
  localparam int STEPS       = 16;
  localparam int FRAC        = 7;
  localparam int ROUND_SHIFT = 16 - FRAC;

  // Angles inside the predictor are carried in 1/65536 degree
  localparam longint DEG_UNIT    = 65536;
  localparam longint RIGHT_ANGLE = 90 * DEG_UNIT;
  localparam longint HALF_TURN   = 180 * DEG_UNIT;
  localparam longint FLOOR_DEG   = 512;  // offset that keeps the rounding input positive

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int LONG_HOLD    = 400;  // cycles the angle side holds off under pressure
  localparam int TAIL_CYCLES  = 80;   // idle tail, longer than one beat's latency
  localparam int PHASES       = 5;
  localparam int PHASE_BEATS  = 150;
  localparam int MAX_REPORTS  = 10;

  // Register map of the config port
  typedef enum logic [ptt_pkg::CFG_IDX_W-1:0] {
    REG_EYE_X = ptt_pkg::CFG_EYE_X,
    REG_EYE_Y = ptt_pkg::CFG_EYE_Y,
    REG_EYE_Z = ptt_pkg::CFG_EYE_Z,
    REG_UNUSED
  } eye_reg_e;

  typedef enum logic {
    ROW_TARGET,
    ROW_WRITE
  } row_kind_e;

  // Coordinate pick styles for the camera position
  typedef enum int {
    EYE_ANY,
    EYE_CORNER,
    EYE_NEAR_ORIGIN
  } eye_style_e;

  typedef struct packed {
    logic [ptt_pkg::PAN_W-1:0]         pan;
    logic signed [ptt_pkg::TILT_W-1:0] tilt;
    logic                              pan_up;
    logic                              tilt_up;
  } angles_t;

  // One line of the directed plan: either a target beat or a register write
  typedef struct {
    row_kind_e                 kind;
    eye_reg_e                  reg_idx;
    logic [ptt_pkg::POS_W-1:0] x;
    logic [ptt_pkg::POS_W-1:0] y;
    logic [ptt_pkg::POS_W-1:0] z;
    logic                      typed;
    angles_t                   want;
  } row_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [ptt_pkg::CFG_IDX_W-1:0]        cfg_index_i;
  logic [ptt_pkg::POS_W-1:0]            cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic signed [ptt_pkg::POS_W-1:0]     target_x_i;
  logic signed [ptt_pkg::POS_W-1:0]     target_y_i;
  logic signed [ptt_pkg::POS_W-1:0]     target_z_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic [ptt_pkg::PAN_W-1:0]            pan_angle_o;
  logic signed [ptt_pkg::TILT_W-1:0]    tilt_angle_o;
  logic                                 pan_updated_o;
  logic                                 tilt_updated_o;

  pan_tilt_angles_to_target #(
    .CORDIC_STEPS   (STEPS),
    .ANGLE_FRAC_BITS(FRAC)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .target_z_i    (target_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pan_angle_o   (pan_angle_o),
    .tilt_angle_o  (tilt_angle_o),
    .pan_updated_o (pan_updated_o),
    .tilt_updated_o(tilt_updated_o)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: camera position, held angles, and the queue of angle
  // beats still owed by the DUT (oldest first).
  // ---------------------------------------------------------------------------
  logic signed [ptt_pkg::POS_W-1:0]  eye_x;
  logic signed [ptt_pkg::POS_W-1:0]  eye_y;
  logic signed [ptt_pkg::POS_W-1:0]  eye_z;
  logic [ptt_pkg::PAN_W-1:0]         held_pan;
  logic signed [ptt_pkg::TILT_W-1:0] held_tilt;
  angles_t                           angle_q[$];

  // atan(2^-i) in 1/65536 degree
  longint atan_step [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Sideband from the target driver: directed rows may carry a hand-typed answer
  logic    row_typed;
  angles_t row_want;

  // Idling control shared by both sides
  bit calm;            // no gaps, no stalls while set
  int hold_asked;      // bumped by the target driver to request a long hold-off
  int hold_served;

  // Run statistics
  int mismatches;
  int targets_seen;
  int angles_seen;
  int eye_writes;
  int pan_holds;
  int tilt_holds;
  int in_stall_cycles;

  // Floor square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = n;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // CORDIC vectoring: atan2(vy, vx) for vx >= 0, in 1/65536 degree
  function automatic longint cordic_angle(input longint vx, input longint vy);
    longint x;
    longint y;
    longint z;
    longint sx;
    longint sy;
    x = vx;
    y = vy;
    z = 0;
    if (x == 0) return (y > 0) ? RIGHT_ANGLE : ((y < 0) ? -RIGHT_ANGLE : 64'sd0);
    for (int i = 0; i < STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x = x + sx;
        y = y - sy;
        z = z + atan_step[i];
      end else begin
        x = x - sx;
        y = y + sy;
        z = z - atan_step[i];
      end
    end
    return z;
  endfunction

  // Round half up to output units, then clamp to [lo_deg, hi_deg]
  function automatic longint round_sat(input longint v, input longint lo_deg,
                                       input longint hi_deg);
    longint lo;
    longint hi;
    longint biased;
    longint r;
    lo     = lo_deg * (longint'(1) << FRAC);
    hi     = hi_deg * (longint'(1) << FRAC);
    biased = v + FLOOR_DEG * DEG_UNIT;
    if (biased < 0) biased = 0;
    r = ((biased + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT)
        - FLOOR_DEG * (longint'(1) << FRAC);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Angles for one target beat; updates the held pan/tilt as the DUT does
  function automatic angles_t predict_angles(input logic signed [ptt_pkg::POS_W-1:0] tx,
                                             input logic signed [ptt_pkg::POS_W-1:0] ty,
                                             input logic signed [ptt_pkg::POS_W-1:0] tz);
    longint          a;
    longint          b;
    longint          c;
    longint          theta;
    longint          h;
    longint          q;
    longint unsigned sq;
    angles_t         res;
    a = longint'(eye_x) - longint'(tx);
    b = longint'(ty) - longint'(eye_y);
    c = longint'(tz) - longint'(eye_z);
    res.pan_up  = (a != 0);
    res.tilt_up = (c != 0);
    if (a != 0) begin
      // dy of zero: straight left or right instead of a divide by zero
      if (b == 0) theta = (a > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
      else if (b > 0) theta = cordic_angle(b * DEG_UNIT, a * DEG_UNIT);
      else theta = cordic_angle(-b * DEG_UNIT, -a * DEG_UNIT);
      theta    = theta + HALF_TURN + ((b > 0) ? HALF_TURN : 64'sd0);
      q        = round_sat(theta, 90, 450);
      held_pan = q[ptt_pkg::PAN_W-1:0];
    end
    if (c != 0) begin
      sq        = a * a + b * b;
      h         = longint'(int_sqrt(sq << 14));
      theta     = cordic_angle(h * 512, c * 128 * 512);
      q         = round_sat(theta, -90, 90);
      held_tilt = q[ptt_pkg::TILT_W-1:0];
    end
    res.pan  = held_pan;
    res.tilt = held_tilt;
    return res;
  endfunction

  task automatic note_mismatch(input bit has_want, input angles_t want, input angles_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (has_want)
        $display("angle beat %0d: want pan %0d tilt %0d upd %b%b, got pan %0d tilt %0d upd %b%b",
                 angles_seen, want.pan, want.tilt, want.pan_up, want.tilt_up,
                 got.pan, got.tilt, got.pan_up, got.tilt_up);
      else
        $display("angle beat %0d with nothing owed: pan %0d tilt %0d upd %b%b",
                 angles_seen, got.pan, got.tilt, got.pan_up, got.tilt_up);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard. Everything happens on the rising edge in one process, so the
  // order of check, prediction and config update is fixed: the angle beat
  // leaving this edge is checked first, then a target beat accepted here is
  // predicted, then a register write lands for the beats after it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    angles_t got;
    angles_t want;
    if (!rst_ni) begin
      eye_x     = '0;
      eye_y     = '0;
      eye_z     = '0;
      held_pan  = '0;
      held_tilt = '0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        angles_seen++;
        got = {pan_angle_o, tilt_angle_o, pan_updated_o, tilt_updated_o};
        if (angle_q.size() == 0) begin
          note_mismatch(1'b0, '0, got);
        end else begin
          want = angle_q.pop_front();
          if (got.pan !== want.pan || got.tilt !== want.tilt ||
              got.pan_up !== want.pan_up || got.tilt_up !== want.tilt_up)
            note_mismatch(1'b1, want, got);
        end
      end
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if (in_valid_i && !in_stall_o) begin
        targets_seen++;
        want = predict_angles(target_x_i, target_y_i, target_z_i);
        if (row_typed) want = row_want;
        if (!want.pan_up) pan_holds++;
        if (!want.tilt_up) tilt_holds++;
        angle_q.push_back(want);
      end
      if (cfg_we_i) begin
        eye_writes++;
        case (eye_reg_e'(cfg_index_i))
          REG_EYE_X: eye_x = cfg_data_i;
          REG_EYE_Y: eye_y = cfg_data_i;
          REG_EYE_Z: eye_z = cfg_data_i;
          default: ;  // unmapped index, no register behind it
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Angle side: random stall bursts, mostly short, a few long, plus the
  // requested long hold-off. The hold length is counted here.
  // ---------------------------------------------------------------------------
  initial begin : angle_sink
    int stall_left;
    int r;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (hold_served != hold_asked) begin
        hold_served++;
        out_stall_i = 1'b1;
        stall_left  = LONG_HOLD - 1;
      end else if (calm) begin
        out_stall_i = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i = 1'b0;
        end else begin
          out_stall_i = 1'b1;
          stall_left  = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Target side helpers
  // ---------------------------------------------------------------------------
  function automatic int next_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Random position anywhere in the field range
  function automatic logic [ptt_pkg::POS_W-1:0] rand_pos();
    logic [31:0] raw;
    raw = $urandom();
    return raw[ptt_pkg::POS_W-1:0];
  endfunction

  // Offset of random magnitude, either sign; zero now and then
  function automatic logic [ptt_pkg::POS_W-1:0] rand_offset();
    int                        m;
    logic [ptt_pkg::POS_W-1:0] v;
    m = $urandom_range(0, 20);
    v = rand_pos() & ((24'd1 << m) - 24'd1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [ptt_pkg::POS_W-1:0] rand_eye(input eye_style_e style);
    case (style)
      EYE_CORNER:      return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      EYE_NEAR_ORIGIN: return rand_offset();
      default:         return rand_pos();
    endcase
  endfunction

  // Mostly targets near the camera, with whole axes lined up to force the
  // hold and zero-dy paths; the rest anywhere in the field range
  task automatic pick_target(output logic [ptt_pkg::POS_W-1:0] x,
                             output logic [ptt_pkg::POS_W-1:0] y,
                             output logic [ptt_pkg::POS_W-1:0] z);
    int r;
    r = $urandom_range(0, 99);
    x = eye_x + rand_offset();
    y = eye_y + rand_offset();
    z = eye_z + rand_offset();
    if (r < 40) begin
    end else if (r < 52) begin
      x = eye_x;
    end else if (r < 64) begin
      z = eye_z;
    end else if (r < 72) begin
      y = eye_y;
    end else if (r < 76) begin
      x = eye_x;
      y = eye_y;
      z = eye_z;
    end else if (r < 80) begin
      x = eye_x;
      z = eye_z;
    end else begin
      x = rand_pos();
      y = rand_pos();
      z = rand_pos();
    end
  endtask

  // Offer one target beat after 'gap' idle cycles and wait until it is taken.
  // Valid stays high when the next beat follows with no gap.
  task automatic drive_target(input logic [ptt_pkg::POS_W-1:0] x,
                              input logic [ptt_pkg::POS_W-1:0] y,
                              input logic [ptt_pkg::POS_W-1:0] z,
                              input int gap, input logic typed, input angles_t want);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    target_x_i = x;
    target_y_i = y;
    target_z_i = z;
    row_typed  = typed;
    row_want   = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop offering and wait until every owed angle beat has been seen
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (angle_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input eye_reg_e idx, input logic [ptt_pkg::POS_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_eye(input logic [ptt_pkg::POS_W-1:0] x,
                         input logic [ptt_pkg::POS_W-1:0] y,
                         input logic [ptt_pkg::POS_W-1:0] z);
    drain();
    write_reg(REG_EYE_X, x);
    write_reg(REG_EYE_Y, y);
    write_reg(REG_EYE_Z, z);
    end_writes();
  endtask

  // Directed plan
  row_t plan[$];

  task automatic add_target(input logic [ptt_pkg::POS_W-1:0] x,
                            input logic [ptt_pkg::POS_W-1:0] y,
                            input logic [ptt_pkg::POS_W-1:0] z);
    row_t row;
    row.kind    = ROW_TARGET;
    row.reg_idx = REG_EYE_X;
    row.x       = x;
    row.y       = y;
    row.z       = z;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endtask

  task automatic add_typed(input logic [ptt_pkg::POS_W-1:0] x,
                           input logic [ptt_pkg::POS_W-1:0] y,
                           input logic [ptt_pkg::POS_W-1:0] z,
                           input int pan, input int tilt, input bit pan_up, input bit tilt_up);
    row_t row;
    row.kind         = ROW_TARGET;
    row.reg_idx      = REG_EYE_X;
    row.x            = x;
    row.y            = y;
    row.z            = z;
    row.typed        = 1'b1;
    row.want.pan     = pan[ptt_pkg::PAN_W-1:0];
    row.want.tilt    = tilt[ptt_pkg::TILT_W-1:0];
    row.want.pan_up  = pan_up;
    row.want.tilt_up = tilt_up;
    plan.push_back(row);
  endtask

  task automatic add_write(input eye_reg_e idx, input logic [ptt_pkg::POS_W-1:0] data);
    row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.x       = data;
    row.y       = '0;
    row.z       = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t                      row;
    logic [ptt_pkg::POS_W-1:0] tx;
    logic [ptt_pkg::POS_W-1:0] ty;
    logic [ptt_pkg::POS_W-1:0] tz;
    int                        gap;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_EYE_X;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    target_x_i  = '0;
    target_y_i  = '0;
    target_z_i  = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    calm        = 1'b0;
    hold_asked  = 0;
    hold_served = 0;

    // Camera at the origin after reset. Held angles start at zero, so a
    // target on the camera's x and z gives zeros with no update flags.
    add_typed(24'h000000, 24'h000000, 24'h000000, 0, 0, 1'b0, 1'b0);
    add_typed(24'h000000, 24'h000100, 24'h000000, 0, 0, 1'b0, 1'b0);
    // dy zero: pan is exactly 270 or 90 degrees by the sign of dx
    add_typed(24'hFFFF00, 24'h000000, 24'h000000, 270 * 128, 0, 1'b1, 1'b0);
    add_typed(24'h000100, 24'h000000, 24'h000000, 90 * 128, 0, 1'b1, 1'b0);
    // Straight above / below: horizontal distance zero, tilt pinned at +-90
    add_typed(24'h000000, 24'h000000, 24'h000100, 90 * 128, 90 * 128, 1'b0, 1'b1);
    add_typed(24'h000000, 24'h000000, 24'hFFFF00, 90 * 128, -90 * 128, 1'b0, 1'b1);
    // Diagonals on both sides of y, one step of tilt off vertical
    add_target(24'hFFFF00, 24'h000100, 24'h000000);
    add_target(24'hFFFF00, 24'hFFFF00, 24'h000100);
    add_target(24'hFFFFFF, 24'h000000, 24'h7FFFFF);
    // Target field extremes
    add_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    add_target(24'h800000, 24'h7FFFFF, 24'h800000);
    // Camera in one corner: differences reach their full 25-bit span
    add_write(REG_EYE_X, 24'h800000);
    add_write(REG_EYE_Y, 24'h7FFFFF);
    add_write(REG_EYE_Z, 24'h800000);
    add_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    add_target(24'h800000, 24'h7FFFFF, 24'h800000);
    add_target(24'h800000, 24'h800000, 24'h7FFFFF);
    // Opposite corner
    add_write(REG_EYE_X, 24'h7FFFFF);
    add_write(REG_EYE_Y, 24'h800000);
    add_write(REG_EYE_Z, 24'h7FFFFF);
    add_target(24'h800000, 24'h7FFFFF, 24'h800000);
    add_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    // A write to the unmapped index must leave the camera alone
    add_write(REG_UNUSED, 24'h5A5A5A);
    add_target(24'h7FFFFE, 24'h800001, 24'h000000);
    add_write(REG_EYE_X, 24'h000000);
    add_write(REG_EYE_Y, 24'h000000);
    add_write(REG_EYE_Z, 24'h000000);
    add_target(24'h000000, 24'h000000, 24'h000000);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.reg_idx, row.x);
        end_writes();
      end else begin
        drive_target(row.x, row.y, row.z, next_gap(), row.typed, row.want);
      end
    end

    // Random phases, each with its own camera position
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       set_eye(rand_eye(EYE_CORNER), rand_eye(EYE_CORNER), rand_eye(EYE_CORNER));
        2:       set_eye(rand_eye(EYE_NEAR_ORIGIN), rand_eye(EYE_NEAR_ORIGIN),
                         rand_eye(EYE_NEAR_ORIGIN));
        default: set_eye(rand_eye(EYE_ANY), rand_eye(EYE_ANY), rand_eye(EYE_ANY));
      endcase
      // Back-pressure: the angle side holds off while beats keep coming
      if (p == 2) hold_asked++;
      // A stretch with no idling on either side
      if (p == 3) calm = 1'b1;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // Sender pause until everything owed has come back
        if (p == 0 && i == PHASE_BEATS / 2) drain();
        if (p == 3 && i == 100) calm = 1'b0;
        pick_target(tx, ty, tz);
        gap = (p == 2 && i < 12) ? 0 : next_gap();
        drive_target(tx, ty, tz, gap, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d target beats over %0d camera positions (%0d writes), %0d angle beats",
             targets_seen, PHASES + 4, eye_writes, angles_seen);
    $display("pan held on %0d beats, tilt held on %0d, target side stalled %0d cycles",
             pan_holds, tilt_holds, in_stall_cycles);
    if (mismatches == 0 && angle_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
